// ----- rtl/core/fas_pkg.sv -----
`timescale 1ns / 1ps

package fas_pkg;

  localparam int FLASH_WORDS = 16384;
  localparam int PAGE_WORDS  = 2048;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = $clog2(FLASH_WORDS);
  localparam int PTR_W   = ADDR_W + 1;
  localparam int PAGE_W  = $clog2(PAGE_WORDS);
  localparam int START_W = 14;
  localparam int ACT_W   = 3;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  localparam logic [WORD_W-1:0] ERASED_WORD = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] FLASH_LIMIT = WORD_W'(FLASH_WORDS);
  localparam logic [PTR_W-1:0]  FLASH_END   = PTR_W'(FLASH_WORDS);

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_RESERVE = 3'd2,
    ACT_MARK    = 3'd3,
    ACT_REWIND  = 3'd4,
    ACT_RESTART = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MARK,
    ST_READ,
    ST_TEST,
    ST_FILL,
    ST_FREE
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              sub;
  } alu_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic              carry;
    logic              above;
  } alu_res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- rtl/core/fas_alu.sv -----
`timescale 1ns / 1ps

module fas_alu (
  input  fas_pkg::alu_op_t  op,
  output fas_pkg::alu_res_t res
);
  import fas_pkg::*;

  logic [WORD_W:0] full;

  // sub: a - b, carry set when a >= b
  always_comb begin
    full = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {{WORD_W{1'b0}}, op.sub};
    res.sum   = full[WORD_W-1:0];
    res.carry = full[WORD_W];
    res.above = full[WORD_W-1:0] > FLASH_LIMIT;
  end

endmodule

// ----- rtl/core/fas_flash_mem.sv -----
`timescale 1ns / 1ps

module fas_flash_mem (
  input  logic                          clk,
  input  fas_pkg::mem_req_t             req,
  output logic [fas_pkg::WORD_W-1:0]    rd_data
);
  import fas_pkg::*;

  logic [WORD_W-1:0] mem [FLASH_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ----- rtl/core/fas_ctrl.sv -----
`timescale 1ns / 1ps

module fas_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fas_pkg::START_W-1:0]   cfg_wdata,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [fas_pkg::ACT_W-1:0]     action,
  input  logic [fas_pkg::WORD_W-1:0]    data_word,
  input  logic [fas_pkg::ADDR_W-1:0]    target_address,
  input  logic [fas_pkg::PTR_W-1:0]     word_count,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          status,
  output logic [fas_pkg::PTR_W-1:0]     location,
  output logic                          page_erased,
  output logic [fas_pkg::PTR_W-1:0]     free_words,
  output fas_pkg::mem_req_t             mem_req,
  input  logic [fas_pkg::WORD_W-1:0]    rd_data
);
  import fas_pkg::*;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [START_W-1:0] app_start;
  logic [WORD_W-1:0]  ptr;
  logic [WORD_W-1:0]  common;

  action_t            act;
  logic [WORD_W-1:0]  data_r;
  logic [PTR_W-1:0]   cursor;
  logic [PTR_W-1:0]   cnt_r;
  logic [PTR_W-1:0]   rsv_end;
  logic [WORD_W-1:0]  tmp;
  logic [PTR_W-1:0]   loc;
  logic               status_r;
  logic               erased_r;

  alu_op_t            alu_op;
  alu_res_t           alu_res;

  logic               s_accept;
  logic               out_load;
  logic [PTR_W-1:0]   cursor_inc;
  logic               page_last;
  logic               rd_dirty;
  logic               need_erase;
  logic               done_test;
  logic               done_fill;
  logic               ptr_commit;

  fas_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign s_ready  = (state == ST_IDLE);
  assign s_accept = s_valid && s_ready;
  assign out_load = (state == ST_FREE) && (!m_valid || m_ready);

  always_comb begin
    cursor_inc = cursor + 1'b1;
    page_last  = &cursor[PAGE_W-1:0];
    rd_dirty   = (rd_data != ERASED_WORD);
    need_erase = rd_dirty && (rd_data != data_r);
    if (act == ACT_RESERVE) begin
      done_test = !rd_dirty && (cursor_inc == rsv_end);
      done_fill = page_last && (cursor_inc >= rsv_end);
    end else begin
      done_test = !need_erase || page_last;
      done_fill = page_last;
    end
    ptr_commit = ((state == ST_TEST && done_test) || (state == ST_FILL && done_fill)) &&
                 (act == ACT_APPEND || act == ACT_RESERVE);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (&clr_cnt) state_next = ST_IDLE;
      ST_IDLE:  if (s_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (act)
          ACT_APPEND, ACT_WRITE: state_next = alu_res.above ? ST_FREE : ST_READ;
          ACT_RESERVE: begin
            state_next = (alu_res.above || cnt_r == '0) ? ST_FREE : ST_READ;
          end
          ACT_MARK: state_next = alu_res.carry ? ST_MARK : ST_FREE;
          default:  state_next = ST_FREE;
        endcase
      end
      ST_MARK: state_next = ST_FREE;
      ST_READ: state_next = ST_TEST;
      ST_TEST: begin
        if (done_test) begin
          state_next = ST_FREE;
        end else if (act == ACT_RESERVE && !rd_dirty) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (page_last) state_next = done_fill ? ST_FREE : ST_READ;
      end
      ST_FREE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // memory request and shared unit operands
  always_comb begin
    mem_req = '0;
    alu_op  = '0;
    case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt;
        mem_req.wdata = ERASED_WORD;
      end
      ST_EXEC: begin
        case (act)
          ACT_APPEND: begin
            alu_op.a = ptr;
            alu_op.b = WORD_W'(1);
          end
          ACT_WRITE: begin
            alu_op.a = {{(WORD_W-PTR_W){1'b0}}, cursor};
            alu_op.b = WORD_W'(1);
          end
          ACT_RESERVE: begin
            alu_op.a = ptr;
            alu_op.b = {{(WORD_W-PTR_W){1'b0}}, cnt_r};
          end
          ACT_MARK: begin
            alu_op.a   = ptr;
            alu_op.b   = {{(WORD_W-START_W){1'b0}}, app_start};
            alu_op.sub = 1'b1;
          end
          ACT_REWIND: begin
            alu_op.a = {{(WORD_W-START_W){1'b0}}, app_start};
            alu_op.b = common;
          end
          default: alu_op.a = ptr;
        endcase
      end
      ST_MARK: begin
        alu_op.a = tmp;
        alu_op.b = WORD_W'(PAGE_WORDS - 1);
      end
      ST_READ: begin
        mem_req.re   = 1'b1;
        mem_req.addr = cursor[ADDR_W-1:0];
      end
      ST_TEST: begin
        if (act != ACT_RESERVE) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = cursor[ADDR_W-1:0];
          mem_req.wdata = data_r;
        end
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = cursor[ADDR_W-1:0];
        mem_req.wdata = ERASED_WORD;
      end
      ST_FREE: begin
        alu_op.a   = FLASH_LIMIT;
        alu_op.b   = ptr;
        alu_op.sub = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      app_start <= '0;
      ptr       <= '0;
      common    <= '0;
      m_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) app_start <= cfg_wdata;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_EXEC: begin
          case (act)
            ACT_REWIND: ptr <= alu_res.sum;
            ACT_RESTART: begin
              ptr    <= {{(WORD_W-START_W){1'b0}}, app_start};
              common <= '0;
            end
            ACT_MARK: if (!alu_res.carry) common <= '0;
            default: ;
          endcase
        end
        ST_MARK: common <= {alu_res.sum[WORD_W-1:PAGE_W], {PAGE_W{1'b0}}};
        ST_TEST, ST_FILL: if (ptr_commit) ptr <= tmp;
        default: ;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      act      <= action_t'(action);
      data_r   <= data_word;
      cursor   <= {1'b0, target_address};
      cnt_r    <= word_count;
      loc      <= ptr[PTR_W-1:0];
      status_r <= 1'b0;
      erased_r <= 1'b0;
    end
    case (state)
      ST_EXEC: begin
        case (act)
          ACT_APPEND: begin
            if (alu_res.above) begin
              status_r <= 1'b1;
            end else begin
              tmp    <= alu_res.sum;
              cursor <= ptr[PTR_W-1:0];
            end
          end
          ACT_WRITE: begin
            loc <= cursor;
            if (alu_res.above) status_r <= 1'b1;
          end
          ACT_RESERVE: begin
            if (alu_res.above) begin
              status_r <= 1'b1;
            end else begin
              tmp     <= alu_res.sum;
              rsv_end <= alu_res.sum[PTR_W-1:0];
              cursor  <= ptr[PTR_W-1:0];
            end
          end
          ACT_MARK: tmp <= alu_res.sum;
          default: ;
        endcase
      end
      ST_TEST: begin
        if (act == ACT_RESERVE) begin
          // a dirty word erases itself and the rest of its page
          if (rd_dirty) begin
            erased_r <= 1'b1;
          end else begin
            cursor <= cursor_inc;
          end
        end else if (need_erase) begin
          erased_r <= 1'b1;
          cursor   <= cursor_inc;
        end
      end
      ST_FILL: cursor <= cursor_inc;
      ST_FREE: begin
        if (out_load) begin
          status      <= status_r;
          location    <= loc;
          page_erased <= erased_r;
          free_words  <= alu_res.carry ? alu_res.sum[PTR_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write in one cycle");

  a_fill_stop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && page_last) |=> state != ST_FILL)
    else $error("fill ran past page end");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> $past(state) == ST_FREE)
    else $error("result loaded outside result step");

  a_cursor_rng: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_FILL) |-> cursor < FLASH_END)
    else $error("cursor beyond flash end");

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    (m_valid && status) |-> !page_erased)
    else $error("overflow item reports an erase");

endmodule

// ----- rtl/core/flash_append_store_with_page_erase_core.sv -----
`timescale 1ns / 1ps
// After reset a clearing pass writes every flash word erased; no item is taken meanwhile.
// Restart, rewind, unused: execute then result; mark adds a mark step when ptr >= start.
// Append, write-at: execute, read, test; a rewrite fills each word up to the page end.
// Reserve: a read and test per word, plus a fill of each page rewrite; overflow: no read.
// One item at a time; the single memory port and shared adder set the rate.
// Reset is synchronous, active high; pointer, common zone and start word go to zero.

module flash_append_store_with_page_erase_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fas_pkg::START_W-1:0]      cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // data_word [31:0], target_address [45:32], word_count [60:46], zero pad
  input  logic [fas_pkg::IN_DATA_W-1:0]    s_tdata,
  // action [2:0]
  input  logic [fas_pkg::ACT_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // location [14:0], page_erased [15], free_words [30:16], zero pad
  output logic [fas_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status [0]
  output logic                             m_tuser
);
  import fas_pkg::*;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;
  logic [PTR_W-1:0]  location;
  logic              page_erased;
  logic [PTR_W-1:0]  free_words;

  fas_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_valid        (s_tvalid),
    .s_ready        (s_tready),
    .action         (s_tuser),
    .data_word      (s_tdata[WORD_W-1:0]),
    .target_address (s_tdata[WORD_W+ADDR_W-1:WORD_W]),
    .word_count     (s_tdata[WORD_W+ADDR_W+PTR_W-1:WORD_W+ADDR_W]),
    .m_valid        (m_tvalid),
    .m_ready        (m_tready),
    .status         (m_tuser),
    .location       (location),
    .page_erased    (page_erased),
    .free_words     (free_words),
    .mem_req        (mem_req),
    .rd_data        (rd_data)
  );

  fas_flash_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign m_tdata = {{(OUT_DATA_W-2*PTR_W-1){1'b0}}, free_words, page_erased, location};

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fas_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    bit        status;
    bit [14:0] location;
    bit        erased;
    bit [14:0] free_words;
  } report_t;

  // Flash image, pointer and zone tracked alongside the block; one report per item.
  class flash_image;
    bit [WORD_W-1:0] words [FLASH_WORDS];
    int unsigned ptr;
    int unsigned zone;
    int unsigned start_word;
    report_t pending[$];
    int errors;

    function new();
      foreach (words[i]) words[i] = ERASED_WORD;
      ptr = 0;
      zone = 0;
      start_word = 0;
      errors = 0;
    endfunction

    // Dirty word: rest of the page from addr on is erased, head is restored.
    function bit program_word(int unsigned addr, bit [WORD_W-1:0] value);
      int unsigned page_end;
      bit rewrote;
      rewrote = 1'b0;
      if (words[addr] != value && words[addr] != ERASED_WORD) begin
        page_end = addr - addr % PAGE_WORDS + PAGE_WORDS;
        for (int unsigned i = addr + 1; i < page_end; i++) words[i] = ERASED_WORD;
        rewrote = 1'b1;
      end
      words[addr] = value;
      return rewrote;
    endfunction

    function void accept_request(logic [ACT_W-1:0] act, bit [WORD_W-1:0] data,
                                 bit [13:0] target, bit [14:0] count);
      report_t r;
      r = '0;
      r.location = ptr[14:0];
      case (act)
        ACT_APPEND: begin
          if (ptr + 1 > FLASH_WORDS) begin
            r.status = 1'b1;
          end else begin
            r.erased = program_word(ptr, data);
            ptr++;
          end
        end
        ACT_WRITE: begin
          r.location = {1'b0, target};
          r.erased = program_word(target, data);
        end
        ACT_RESERVE: begin
          if (ptr + count > FLASH_WORDS) begin
            r.status = 1'b1;
          end else begin
            for (int unsigned i = 0; i < count; i++)
              if (program_word(ptr + i, ERASED_WORD)) r.erased = 1'b1;
            ptr += count;
          end
        end
        ACT_MARK: begin
          if (ptr < start_word) zone = 0;
          else zone = ((ptr - start_word + PAGE_WORDS - 1) / PAGE_WORDS) * PAGE_WORDS;
        end
        ACT_REWIND: ptr = start_word + zone;
        ACT_RESTART: begin
          ptr = start_word;
          zone = 0;
        end
        default: ;
      endcase
      r.free_words = (ptr < FLASH_WORDS) ? 15'(FLASH_WORDS - ptr) : 15'd0;
      pending.push_back(r);
    endfunction

    function void compare_report(bit status, bit [14:0] location, bit erased,
                                 bit [14:0] free_words);
      report_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status=%0d loc=%0d erased=%0d free=%0d",
                   status, location, erased, free_words);
        return;
      end
      e = pending.pop_front();
      bad = 1'b0;
      if (e.status != status) bad = 1'b1;
      if (e.location != location) bad = 1'b1;
      if (e.erased != erased) bad = 1'b1;
      if (e.free_words != free_words) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status=%0d loc=%0d erased=%0d free=%0d | %s%0d %s%0d %s%0d %s%0d",
                   e.status, e.location, e.erased, e.free_words,
                   "got status=", status, "loc=", location,
                   "erased=", erased, "free=", free_words);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [START_W-1:0]      cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [ACT_W-1:0]        s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    m_tuser;

  flash_image store;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  flash_append_store_with_page_erase_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always @(posedge clk) begin
    if (!rst && cfg_we) store.start_word = cfg_wdata;
    if (!rst && s_tvalid && s_tready)
      store.accept_request(s_tuser, s_tdata[31:0], s_tdata[45:32], s_tdata[60:46]);
    if (!rst && m_tvalid && m_tready)
      store.compare_report(m_tuser, m_tdata[14:0], m_tdata[15], m_tdata[30:16]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver backpressure
  initial begin
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input bit [WORD_W-1:0] data,
                           input bit [13:0] target, input bit [14:0] count);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tuser  <= act;
    s_tdata  <= {3'b000, count, target, data};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Block must be idle before the start word changes.
  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (store.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_start_word(input bit [START_W-1:0] value);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned roll;
    logic [ACT_W-1:0] act;
    bit [WORD_W-1:0] data;
    bit [13:0] target;
    bit [14:0] count;
    int unsigned sel;
    roll   = $urandom_range(0, 99);
    data   = $urandom;
    target = 14'($urandom);
    count  = 15'($urandom_range(0, FLASH_WORDS));
    if (roll < 35) act = ACT_APPEND;
    else if (roll < 60) act = ACT_WRITE;
    else if (roll < 75) act = ACT_RESERVE;
    else if (roll < 83) act = ACT_MARK;
    else if (roll < 90) act = ACT_REWIND;
    else if (roll < 95) act = ACT_RESTART;
    else act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
    // rewrites cost up to the page end, so most targets sit near one
    if (act == ACT_WRITE && $urandom_range(0, 9) < 7)
      target = 14'($urandom_range(0, 7) * PAGE_WORDS + PAGE_WORDS - 1 - $urandom_range(0, 63));
    if (act == ACT_RESERVE) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) count = 15'($urandom_range(0, 16));
      else if (sel < 19) count = 15'($urandom_range(17, 300));
      else count = 15'($urandom_range(301, 2500));
    end
    case ($urandom_range(0, 5))
      0: data = ERASED_WORD;
      1: data = '0;
      2: begin
        if (act == ACT_WRITE) data = store.words[target];
        else if (store.ptr < FLASH_WORDS) data = store.words[store.ptr];
      end
      default: ;
    endcase
    send_item(act, data, target, count);
  endtask

  initial begin
    store = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_start_word(14'd0);
    send_item(ACT_APPEND, 32'h0000_0000, 14'd0, 15'd0);
    send_item(ACT_APPEND, ERASED_WORD, 14'd0, 15'd0);
    send_item(ACT_APPEND, 32'hA5A5_A5A5, 14'd0, 15'd0);
    send_item(ACT_WRITE, 32'h1234_5678, 14'd0, 15'd0);      // dirty word, page rewrite
    send_item(ACT_WRITE, 32'h1234_5678, 14'd0, 15'd0);      // same value, plain program
    send_item(ACT_WRITE, ERASED_WORD, 14'd16383, 15'd0);
    send_item(ACT_WRITE, 32'h0000_0000, 14'd16383, 15'd0);
    send_item(ACT_WRITE, 32'h0000_0001, 14'd16383, 15'd0);  // last word of flash
    send_item(ACT_WRITE, 32'h0000_0007, 14'd2047, 15'd0);
    send_item(ACT_RESERVE, 32'h0, 14'd0, 15'd0);
    send_item(ACT_RESERVE, 32'h0, 14'd0, 15'd5);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    send_item(ACT_APPEND, 32'h3C3C_3C3C, 14'd0, 15'd0);
    send_item(ACT_REWIND, 32'h0, 14'd0, 15'd0);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    send_item(ACT_RESTART, 32'h0, 14'd0, 15'd0);
    send_item(ACT_RESERVE, 32'hFFFF_0000, 14'h3FFF, 15'd16384);
    send_item(ACT_APPEND, 32'h5A5A_5A5A, 14'd0, 15'd0);     // full flash
    send_item(ACT_RESERVE, 32'h0, 14'd0, 15'd1);
    send_item(ACT_RESERVE, 32'h0, 14'd0, 15'd0);
    send_item(ACT_WRITE, $urandom, 14'd5, 15'd0);
    send_item(ACT_SPARE6, $urandom, 14'($urandom), 15'd16384);
    send_item(ACT_SPARE7, $urandom, 14'($urandom), 15'd0);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    send_item(ACT_REWIND, 32'h0, 14'd0, 15'd0);
    send_item(ACT_RESTART, 32'h0, 14'd0, 15'd0);

    set_start_word(14'd16383);
    send_item(ACT_RESTART, 32'h0, 14'd0, 15'd0);
    send_item(ACT_APPEND, 32'hDEAD_BEEF, 14'd0, 15'd0);
    send_item(ACT_APPEND, 32'hDEAD_BEEF, 14'd0, 15'd0);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    send_item(ACT_REWIND, 32'h0, 14'd0, 15'd0);             // pointer beyond the end
    send_item(ACT_RESERVE, 32'h0, 14'd0, 15'd0);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    set_start_word(14'd100);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);
    send_item(ACT_REWIND, 32'h0, 14'd0, 15'd0);
    send_item(ACT_RESTART, 32'h0, 14'd0, 15'd0);
    set_start_word(14'd16383);
    send_item(ACT_MARK, 32'h0, 14'd0, 15'd0);               // pointer below start
    send_item(ACT_REWIND, 32'h0, 14'd0, 15'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_start_word(14'($urandom_range(0, 16383)));
        1: set_start_word(14'd0);
        2: set_start_word(14'($urandom_range(12000, 16383)));
        default: set_start_word(14'($urandom_range(0, 16383)));
      endcase
      if (phase == 3) quiet = 1'b1;
      send_item(ACT_RESTART, $urandom, 14'($urandom), 15'd0);
      repeat (118) random_item();
    end

    wait_until_drained();
    repeat (20) @(posedge clk);
    if (store.errors == 0 && store.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
